[sv/hbc_pkg.sv]
package hbc_pkg;

    // Sizing of the count store.
    localparam int MAX_BINS    = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_SLOTS   = MAX_BINS + 2;
    localparam int IDX_W       = $clog2(BIN_SLOTS);

    // Fixed field widths of the request and result channels.
    localparam int ACTION_W    = 2;
    localparam int SAMPLE_W    = 32;
    localparam int RIDX_W      = 7;
    localparam int OUT_VAL_W   = 32;

    // Configuration register widths and port.
    localparam int START_W     = 32;
    localparam int WIDTH_W     = 31;
    localparam int BCOUNT_W    = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Divider sizing: the quotient is always below the bin count.
    localparam int Q_W         = $clog2(MAX_BINS + 1);
    localparam int K_W         = (Q_W > 1) ? $clog2(Q_W) : 1;
    localparam int DIFF_W      = SAMPLE_W;
    localparam int PROD_W      = WIDTH_W + IDX_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_EDGE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT   = 2'd2;

    // Request actions.
    localparam logic [ACTION_W-1:0] ACT_ACCUM = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic load;      // capture the accepted request
        logic idx_read;  // bin index from the read request
        logic idx_cmp;   // bin index from the range checks
        logic div_init;  // start the quotient search
        logic div_step;  // one quotient bit
        logic upd;       // count read back: update and load the result
        logic out_zero;  // all-zero result
        logic out_bad;   // bad read index result
        logic clear;     // forget every count
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                under;
        logic                over;
        logic                bad;
        logic                div_last;
    } t_stat;

endpackage

[sv/hbc_in_if.sv]
interface hbc_in_if
    import hbc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SAMPLE_W-1:0] sample;
    logic [RIDX_W-1:0]   read_index;

    modport source (output valid, output action, output sample, output read_index,
                    input ready);
    modport sink   (input valid, input action, input sample, input read_index,
                    output ready);
endinterface

[sv/hbc_out_if.sv]
interface hbc_out_if
    import hbc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [RIDX_W-1:0]    bin_index;
    logic [OUT_VAL_W-1:0] bin_value;
    logic                 bad_index;

    modport source (output valid, output bin_index, output bin_value, output bad_index,
                    input ready);
    modport sink   (input valid, input bin_index, input bin_value, input bad_index,
                    output ready);
endinterface

[sv/hbc_ram.sv]
module hbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 66
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/hbc_dpath.sv]
module hbc_dpath
    import hbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic [RIDX_W-1:0]     i_read_index,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic [RIDX_W-1:0]     o_bin_index,
    output logic [OUT_VAL_W-1:0]  o_bin_value,
    output logic                  o_bad_index
);
    logic [START_W-1:0]     r_low_edge;
    logic [WIDTH_W-1:0]     r_bin_width;
    logic [BCOUNT_W-1:0]    r_bin_count;

    logic [ACTION_W-1:0]    r_action;
    logic [SAMPLE_W-1:0]    r_sample;
    logic [RIDX_W-1:0]      r_read_index;

    logic [DIFF_W-1:0]      r_diff;
    logic                   r_under;
    logic [PROD_W-1:0]      r_prod;
    logic [DIFF_W-1:0]      r_rem;
    logic [Q_W-1:0]         r_q;
    logic [K_W-1:0]         r_k;
    logic [IDX_W-1:0]       r_idx;
    logic [BIN_SLOTS-1:0]   r_valid;

    logic [RIDX_W-1:0]      r_out_idx;
    logic [OUT_VAL_W-1:0]   r_out_val;
    logic                   r_out_bad;

    logic [WIDTH_W-1:0]     w_eff;
    logic [IDX_W-1:0]       n_eff;
    logic [DIFF_W:0]        diff_ext;
    logic [PROD_W-1:0]      shifted;
    logic                   fits;
    logic [Q_W-1:0]         n_q;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] new_count;
    logic                   ram_we;

    // Effective configuration: zero width counts as one, bin count is clamped.
    assign w_eff = (r_bin_width == '0) ? WIDTH_W'(1) : r_bin_width;

    always_comb begin
        if (r_bin_count == '0) begin
            n_eff = IDX_W'(1);
        end else if (32'(r_bin_count) > 32'(MAX_BINS)) begin
            n_eff = IDX_W'(MAX_BINS);
        end else begin
            n_eff = IDX_W'(r_bin_count);
        end
    end

    assign diff_ext = {r_sample[SAMPLE_W-1], r_sample}
                    - {r_low_edge[START_W-1], r_low_edge};

    // Restoring division, one quotient bit per cycle, most significant first.
    assign shifted = PROD_W'(w_eff) << r_k;
    assign fits    = PROD_W'(r_rem) >= shifted;
    assign n_q     = r_q | (Q_W'(fits) << r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_edge  <= '0;
            r_bin_width <= WIDTH_W'(1);
            r_bin_count <= BCOUNT_W'(MAX_BINS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_EDGE:  r_low_edge  <= START_W'(i_cfg_data);
                CFG_BIN_WIDTH: r_bin_width <= WIDTH_W'(i_cfg_data);
                CFG_BIN_COUNT: r_bin_count <= BCOUNT_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action     <= i_action;
            r_sample     <= i_sample;
            r_read_index <= i_read_index;
        end
        // Difference and range limit are taken every cycle; the controller
        // only looks at them once the request has been captured.
        r_diff  <= diff_ext[DIFF_W-1:0];
        r_under <= diff_ext[DIFF_W];
        r_prod  <= PROD_W'(w_eff) * PROD_W'(n_eff);

        if (i_cmd.div_init) begin
            r_rem <= r_diff;
            r_q   <= '0;
            r_k   <= K_W'(Q_W - 1);
        end else if (i_cmd.div_step) begin
            if (fits) begin
                r_rem <= DIFF_W'(PROD_W'(r_rem) - shifted);
            end
            r_q <= n_q;
            r_k <= r_k - K_W'(1);
        end

        if (i_cmd.idx_read) begin
            r_idx <= IDX_W'(r_read_index);
        end else if (i_cmd.idx_cmp) begin
            r_idx <= r_under ? '0 : (n_eff + IDX_W'(1));
        end else if (i_cmd.div_step && r_k == '0) begin
            r_idx <= IDX_W'(n_q) + IDX_W'(1);
        end

        if (i_cmd.out_zero) begin
            r_out_idx <= '0;
            r_out_val <= '0;
            r_out_bad <= 1'b0;
        end else if (i_cmd.out_bad) begin
            r_out_idx <= r_read_index;
            r_out_val <= '0;
            r_out_bad <= 1'b1;
        end else if (i_cmd.upd) begin
            r_out_idx <= RIDX_W'(r_idx);
            r_out_val <= OUT_VAL_W'((r_action == ACT_ACCUM) ? new_count : cur_count);
            r_out_bad <= 1'b0;
        end
    end

    // A bin that has not been written since reset or the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    assign cur_count = r_valid[r_idx] ? ram_rdata : '0;
    assign new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_WIDTH'(1);
    assign ram_we    = i_cmd.upd && (r_action == ACT_ACCUM);

    hbc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (BIN_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (new_count),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_stat.action   = r_action;
    assign o_stat.under    = r_under;
    assign o_stat.over     = !r_under && (PROD_W'(r_diff) >= r_prod);
    assign o_stat.bad      = 32'(r_read_index) > (32'(n_eff) + 32'd1);
    assign o_stat.div_last = (r_k == '0);

    assign o_bin_index = r_out_idx;
    assign o_bin_value = r_out_val;
    assign o_bad_index = r_out_bad;

    a_clear_forgets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_valid == '0)
        else $error("count store still holds valid bins after a clear");

    a_idx_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> 32'(r_idx) <= (32'(n_eff) + 32'd1))
        else $error("count update aimed beyond the overflow bin");
endmodule

[sv/hbc_ctrl.sv]
module hbc_ctrl
    import hbc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_PREP;
                end
            end
            ST_PREP: begin
                case (i_stat.action)
                    ACT_ACCUM: begin
                        n_state = ST_CMP;
                    end
                    ACT_READ: begin
                        if (i_stat.bad) begin
                            o_cmd.out_bad = 1'b1;
                            n_state       = ST_OUT;
                        end else begin
                            o_cmd.idx_read = 1'b1;
                            n_state        = ST_RD;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.clear    = 1'b1;
                        o_cmd.out_zero = 1'b1;
                        n_state        = ST_OUT;
                    end
                    default: begin
                        o_cmd.out_zero = 1'b1;
                        n_state        = ST_OUT;
                    end
                endcase
            end
            ST_CMP: begin
                if (i_stat.under || i_stat.over) begin
                    o_cmd.idx_cmp = 1'b1;
                    n_state       = ST_RD;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_PREP)
        else $error("accepted request did not start processing");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !i_out_ready) |=> r_state == ST_OUT)
        else $error("result dropped before it was taken");

    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd |=> !o_cmd.upd && r_state == ST_OUT)
        else $error("count updated twice for one request");
endmodule

[sv/histogram_binning_counter_unit.sv]
// Channel   Dir  Handshake         Payload
// i_in      in   valid / ready     action[1:0], sample[31:0] signed, read_index[6:0]
// o_out     out  valid / ready     bin_index[6:0], bin_value[31:0], bad_index
// cfg       in   i_cfg_we only     i_cfg_idx[1:0], i_cfg_data[31:0]
//
// One request is processed at a time. An accumulate request inside the binned
// range passes the range check, the quotient search, a store read and update;
// below or above the range it skips the search, a read starts at the store
// read, and a bad read index, a clear or an unused action goes straight out.
// Reset is synchronous and active low; it sets low edge 0, bin width 1 and bin
// count 64, and marks every bin as empty at once, so no clearing pass is needed.
// A result waits in its output register until taken; the next request is
// accepted in the cycle after that.
module histogram_binning_counter_unit
    import hbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hbc_in_if.sink                i_in,
    hbc_out_if.source             o_out
);
    // The controller steps through the phases of a request and the datapath
    // holds the configuration, the bin arithmetic and the count store. The
    // count store is a small RAM whose entries carry a valid bit each, so a
    // clear request empties the whole histogram at once.
    t_cmd  cmd;
    t_stat stat;

    hbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // The bin is found by first checking the underflow and overflow limits
    // (the overflow limit is the product of bin width and bin count, taken
    // in its own register stage), then by dividing the offset from the
    // start of the range by the bin width. The result is then read back from
    // the store, incremented with saturation and written again.
    hbc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_in.action),
        .i_sample     (i_in.sample),
        .i_read_index (i_in.read_index),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_bin_index  (o_out.bin_index),
        .o_bin_value  (o_out.bin_value),
        .o_bad_index  (o_out.bad_index)
    );
endmodule
